>>> rtl/core/unigram_viterbi_segmenter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unigram Viterbi segmenter
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef UNIGRAM_VITERBI_SEGMENTER_MACROS_SVH
`define UNIGRAM_VITERBI_SEGMENTER_MACROS_SVH
`ifndef ASSERT_OFF
`define UVS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define UVS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define UVS_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define UVS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Types and constants of the unigram Viterbi segmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int VOCAB_SLOTS_DEF     = 1024;
  localparam int MAX_TOKEN_BYTES_DEF = 8;
  localparam int MAX_LINE_BYTES_DEF  = 64;

  localparam int KEY_BYTES = 8;
  localparam int SLOT_W    = 10;
  localparam int START_W   = 6;
  localparam int LEN_W     = 4;
  localparam int ESCORE_W  = 16;
  localparam int PSCORE_W  = 24;
  localparam int STATUS_W  = 2;

  localparam logic signed [PSCORE_W-1:0] PSCORE_MAX = 24'sh7FFFFF;
  localparam logic signed [PSCORE_W-1:0] PSCORE_MIN = -24'sh800000;

  localparam logic [STATUS_W-1:0] ST_TOKEN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOPATH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOOLONG = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TEXT  = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [7:0]                 text_byte;
    logic                       end_of_line;
    logic [SLOT_W-1:0]          entry_slot;
    logic [8*KEY_BYTES-1:0]     entry_key;
    logic [LEN_W-1:0]           entry_length;
    logic signed [ESCORE_W-1:0] entry_score;
    logic                       entry_valid;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          token_slot;
    logic [START_W-1:0]         token_start;
    logic [LEN_W-1:0]           token_length;
    logic signed [PSCORE_W-1:0] path_score;
    logic [STATUS_W-1:0]        status;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic                       valid;
    logic [LEN_W-1:0]           length;
    logic signed [ESCORE_W-1:0] score;
    logic [8*KEY_BYTES-1:0]     key;
  } vocab_word_t;

  typedef struct packed {
    logic signed [PSCORE_W-1:0] score;
    logic [SLOT_W-1:0]          slot;
    logic [LEN_W-1:0]           len;
  } line_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } tok_word_t;

endpackage

>>> rtl/core/unigram_viterbi_segmenter.sv
// ----------------------------------------------------------------------------
// unigram_viterbi_segmenter
// Splits text lines into vocabulary tokens with the best summed log score.
// ----------------------------------------------------------------------------
// Usage: in_data carries one item per transfer (in_valid high, in_stall low).
// A write item (mode 0) stores one vocabulary slot and leaves the block idle.
// A text byte (mode 1) scans the whole vocabulary RAM, one slot per cycle,
// then evaluates the candidate token lengths and writes the line memory;
// no new transfer is taken until that is done. A byte of an overlong line
// is dropped.
// At the end of line the trace back reads the line memory in the states
// S_TB_RD and S_TB_USE per token, then results leave through out_data.
// Token results come in line order, the final one flagged last; a line
// with no segmentation or over MAX_LINE_BYTES gives one status result.
// A stall on out_stall holds the output register; the block keeps taking
// items until it needs the output register again.
// After reset a clearing pass over every vocabulary slot wipes the slot valid
// bits; in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "unigram_viterbi_segmenter_macros.svh"
module unigram_viterbi_segmenter #(
  parameter int VOCAB_SLOTS     = uvs_pkg::VOCAB_SLOTS_DEF,
  parameter int MAX_TOKEN_BYTES = uvs_pkg::MAX_TOKEN_BYTES_DEF,
  parameter int MAX_LINE_BYTES  = uvs_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  uvs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output uvs_pkg::out_item_t  out_data
);

  localparam int AW  = $clog2(VOCAB_SLOTS);
  localparam int PW  = $clog2(MAX_LINE_BYTES + 1);
  localparam int LD  = MAX_LINE_BYTES + 1;
  localparam int KIW = (MAX_TOKEN_BYTES > 1) ? $clog2(MAX_TOKEN_BYTES) : 1;
  localparam int KW  = uvs_pkg::LEN_W;
  localparam int VWW = $bits(uvs_pkg::vocab_word_t);
  localparam int LWW = $bits(uvs_pkg::line_word_t);
  localparam int TWW = $bits(uvs_pkg::tok_word_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_EV_RD, S_EV_USE, S_WRITE, S_END,
    S_ST_OUT, S_TB_RD, S_TB_USE, S_POP_RD, S_POP_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] addr_r, addr_nxt;
  logic          issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          too_long_r, too_long_nxt;
  logic          eol_r, eol_nxt;
  logic [LD-1:0] reach_r, reach_nxt;
  logic [7:0]    recent_r [uvs_pkg::KEY_BYTES];
  logic [7:0]    recent_nxt [uvs_pkg::KEY_BYTES];
  logic [MAX_TOKEN_BYTES-1:0] found_r, found_nxt;
  logic [uvs_pkg::SLOT_W-1:0] fslot_r [MAX_TOKEN_BYTES];
  logic [uvs_pkg::SLOT_W-1:0] fslot_nxt [MAX_TOKEN_BYTES];
  logic signed [uvs_pkg::ESCORE_W-1:0] fscore_r [MAX_TOKEN_BYTES];
  logic signed [uvs_pkg::ESCORE_W-1:0] fscore_nxt [MAX_TOKEN_BYTES];
  logic [KW-1:0] k_r, k_nxt;
  logic          cur_reach_r, cur_reach_nxt;
  logic signed [uvs_pkg::PSCORE_W-1:0] cur_best_r, cur_best_nxt;
  logic [uvs_pkg::SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [KW-1:0] cur_len_r, cur_len_nxt;
  logic [PW-1:0] tb_p_r, tb_p_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  uvs_pkg::out_item_t out_r, out_nxt;

  logic                      v_we, v_re;
  logic [AW-1:0]             v_waddr, v_raddr;
  uvs_pkg::vocab_word_t      v_wdata, v_rdata;
  logic                      l_we, l_re;
  logic [PW-1:0]             l_waddr, l_raddr;
  uvs_pkg::line_word_t       l_wdata, l_rdata;
  logic                      t_we, t_re;
  logic [PW-1:0]             t_waddr, t_raddr;
  uvs_pkg::tok_word_t        t_wdata, t_rdata;

  uvs_ram #(.WIDTH(VWW), .DEPTH(VOCAB_SLOTS)) u_vocab (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .re(v_re), .raddr(v_raddr), .rdata(v_rdata)
  );

  uvs_ram #(.WIDTH(LWW), .DEPTH(LD)) u_line (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  uvs_ram #(.WIDTH(TWW), .DEPTH(LD)) u_stack (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  logic [MAX_TOKEN_BYTES-1:0] hit;
  logic [31:0] kmax, slot_ext, start_ext, pidx_ext;
  logic [KIW-1:0] ki;
  logic signed [uvs_pkg::PSCORE_W:0] sum_w;
  logic signed [uvs_pkg::PSCORE_W-1:0] sum_sat;
  logic out_free, accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign kmax      = (32'(pos_r) < MAX_TOKEN_BYTES) ? 32'(pos_r) : MAX_TOKEN_BYTES;
  assign slot_ext  = 32'(in_data.entry_slot);
  assign pidx_ext  = 32'(pidx_r);
  assign ki        = KIW'(32'(k_r) - 32'd1);
  assign start_ext = 32'(pos_r) - 32'(k_r);

  always_comb begin
    logic [8*uvs_pkg::KEY_BYTES-1:0] want, mask;
    for (int kk = 0; kk < MAX_TOKEN_BYTES; kk++) begin
      want = '0;
      mask = '0;
      for (int j = 0; j < MAX_TOKEN_BYTES; j++) begin
        if (j <= kk) begin
          want[8*j +: 8] = recent_r[kk-j];
          mask[8*j +: 8] = 8'hFF;
        end
      end
      hit[kk] = v_rdata.valid && (v_rdata.length == KW'(kk + 1))
                && ((v_rdata.key & mask) == want);
    end
  end

  always_comb begin
    logic signed [uvs_pkg::PSCORE_W-1:0] base;
    base  = (start_ext[PW-1:0] == '0) ? '0 : l_rdata.score;
    sum_w = {base[uvs_pkg::PSCORE_W-1], base}
          + (uvs_pkg::PSCORE_W+1)'(fscore_r[ki]);
    if (sum_w > (uvs_pkg::PSCORE_W+1)'(uvs_pkg::PSCORE_MAX)) begin
      sum_sat = uvs_pkg::PSCORE_MAX;
    end else if (sum_w < (uvs_pkg::PSCORE_W+1)'(uvs_pkg::PSCORE_MIN)) begin
      sum_sat = uvs_pkg::PSCORE_MIN;
    end else begin
      sum_sat = sum_w[uvs_pkg::PSCORE_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    pos_nxt       = pos_r;
    too_long_nxt  = too_long_r;
    eol_nxt       = eol_r;
    reach_nxt     = reach_r;
    recent_nxt    = recent_r;
    found_nxt     = found_r;
    fslot_nxt     = fslot_r;
    fscore_nxt    = fscore_r;
    k_nxt         = k_r;
    cur_reach_nxt = cur_reach_r;
    cur_best_nxt  = cur_best_r;
    cur_slot_nxt  = cur_slot_r;
    cur_len_nxt   = cur_len_r;
    tb_p_nxt      = tb_p_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    v_we = 1'b0; v_waddr = addr_r; v_wdata = '0;
    v_re = 1'b0; v_raddr = addr_r;
    l_we = 1'b0; l_waddr = pos_r; l_wdata = '0;
    l_re = 1'b0; l_raddr = start_ext[PW-1:0];
    t_we = 1'b0; t_waddr = cnt_r; t_wdata = '0;
    t_re = 1'b0; t_raddr = cnt_r;

    unique case (state_r)
      S_CLEAR: begin
        v_we = 1'b1;
        if (32'(addr_r) == VOCAB_SLOTS - 1) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.mode == uvs_pkg::MODE_WRITE) begin
            if (slot_ext < VOCAB_SLOTS) begin
              v_we    = 1'b1;
              v_waddr = slot_ext[AW-1:0];
              v_wdata = '{valid: in_data.entry_valid, length: in_data.entry_length,
                          score: in_data.entry_score, key: in_data.entry_key};
            end
          end else begin
            eol_nxt = in_data.end_of_line;
            if (too_long_r || 32'(pos_r) >= MAX_LINE_BYTES) begin
              too_long_nxt = 1'b1;
              if (in_data.end_of_line) begin
                state_nxt = S_END;
              end
            end else begin
              recent_nxt[0] = in_data.text_byte;
              for (int i = 1; i < uvs_pkg::KEY_BYTES; i++) begin
                recent_nxt[i] = recent_r[i-1];
              end
              pos_nxt            = pos_r + PW'(1);
              reach_nxt[pos_nxt] = 1'b0;
              found_nxt          = '0;
              addr_nxt           = '0;
              issue_nxt          = 1'b1;
              cur_reach_nxt      = 1'b0;
              state_nxt          = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          v_re     = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = addr_r;
          if (32'(addr_r) == VOCAB_SLOTS - 1) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
        if (pend_r) begin
          for (int kk = 0; kk < MAX_TOKEN_BYTES; kk++) begin
            if (hit[kk] && !found_r[kk]) begin
              found_nxt[kk]  = 1'b1;
              fslot_nxt[kk]  = pidx_ext[uvs_pkg::SLOT_W-1:0];
              fscore_nxt[kk] = v_rdata.score;
            end
          end
        end
        if (!issue_r && !pend_r) begin
          k_nxt     = KW'(1);
          state_nxt = S_EV_RD;
        end
      end
      S_EV_RD: begin
        if (32'(k_r) > kmax) begin
          state_nxt = S_WRITE;
        end else if (reach_r[start_ext[PW-1:0]] && found_r[ki]) begin
          l_re      = 1'b1;
          state_nxt = S_EV_USE;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_EV_USE: begin
        if (!cur_reach_r || sum_sat > cur_best_r) begin
          cur_reach_nxt = 1'b1;
          cur_best_nxt  = sum_sat;
          cur_slot_nxt  = fslot_r[ki];
          cur_len_nxt   = k_r;
        end
        k_nxt     = k_r + KW'(1);
        state_nxt = S_EV_RD;
      end
      S_WRITE: begin
        l_we           = cur_reach_r;
        l_wdata        = '{score: cur_best_r, slot: cur_slot_r, len: cur_len_r};
        reach_nxt[pos_r] = cur_reach_r;
        state_nxt      = eol_r ? S_END : S_IDLE;
      end
      S_END: begin
        if (too_long_r || !cur_reach_r) begin
          state_nxt = S_ST_OUT;
        end else begin
          tb_p_nxt  = pos_r;
          cnt_nxt   = '0;
          state_nxt = S_TB_RD;
        end
      end
      S_ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.status = too_long_r ? uvs_pkg::ST_TOOLONG : uvs_pkg::ST_NOPATH;
          out_nxt.last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TB_RD: begin
        l_re      = 1'b1;
        l_raddr   = tb_p_r;
        state_nxt = S_TB_USE;
      end
      S_TB_USE: begin
        t_we     = 1'b1;
        t_wdata  = '{slot: l_rdata.slot,
                     start: uvs_pkg::START_W'(32'(tb_p_r) - 32'(l_rdata.len)),
                     len: l_rdata.len};
        tb_p_nxt = PW'(32'(tb_p_r) - 32'(l_rdata.len));
        if (tb_p_nxt == '0) begin
          state_nxt = S_POP_RD;
        end else begin
          cnt_nxt   = cnt_r + PW'(1);
          state_nxt = S_TB_RD;
        end
      end
      S_POP_RD: begin
        t_re      = 1'b1;
        state_nxt = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{token_slot: t_rdata.slot, token_start: t_rdata.start,
                      token_length: t_rdata.len, path_score: cur_best_r,
                      status: uvs_pkg::ST_TOKEN, last: (cnt_r == '0)};
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r - PW'(1);
            state_nxt = S_POP_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if ((state_r == S_ST_OUT || state_r == S_POP_OUT) && state_nxt == S_IDLE) begin
      pos_nxt      = '0;
      too_long_nxt = 1'b0;
      reach_nxt    = LD'(1);
      for (int i = 0; i < uvs_pkg::KEY_BYTES; i++) begin
        recent_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      too_long_r  <= 1'b0;
      reach_r     <= LD'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < uvs_pkg::KEY_BYTES; i++) begin
        recent_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      too_long_r  <= too_long_nxt;
      reach_r     <= reach_nxt;
      out_valid_r <= out_valid_nxt;
      recent_r    <= recent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    eol_r       <= eol_nxt;
    found_r     <= found_nxt;
    fslot_r     <= fslot_nxt;
    fscore_r    <= fscore_nxt;
    k_r         <= k_nxt;
    cur_reach_r <= cur_reach_nxt;
    cur_best_r  <= cur_best_nxt;
    cur_slot_r  <= cur_slot_nxt;
    cur_len_r   <= cur_len_nxt;
    tb_p_r      <= tb_p_nxt;
    cnt_r       <= cnt_nxt;
    out_r       <= out_nxt;
  end

  `UVS_ASSERT_IMP(a_reach_origin, clk, rst_n, 1'b1, reach_r[0])
  `UVS_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, 32'(pos_r) <= MAX_LINE_BYTES)
  `UVS_ASSERT_IMP(a_status_last, clk, rst_n,
                  out_valid_r && (out_r.status != uvs_pkg::ST_TOKEN), out_r.last)
  `UVS_ASSERT_NEXT(a_clear_stalls, clk, rst_n,
                   state_r == S_CLEAR && 32'(addr_r) != VOCAB_SLOTS - 1, in_stall)

endmodule

>>> rtl/core/uvs_ram.sv
// ----------------------------------------------------------------------------
// uvs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module uvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
